>>> rtl/apmd_pkg.sv
// apmd_pkg.sv - shared widths, operation codes and flow-control types
// for the audio peak meter with decay.
// No dependencies; every other file of the block imports this package.
package apmd_pkg;

    // Field widths of the transaction payloads and the register
    localparam int PEAK_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int SAMPLE_W = 16;
    localparam int CLEN_W   = 16;
    localparam int TIME_W   = 32;
    localparam int IDLE_W   = 16;

    // Operation codes carried by each input transaction
    typedef logic [1:0] op_t;
    localparam op_t OP_CHUNK   = 2'd0;
    localparam op_t OP_SAMPLE  = 2'd1;
    localparam op_t OP_POLL    = 2'd2;
    localparam op_t OP_RESTART = 2'd3;

    localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd20;

    localparam int FULL_SCALE = 32767;
    localparam int PEAK_MAX   = FULL_SCALE + 1;
    localparam int LEVEL_MAX  = 100;
    localparam int MS_PER_S   = 1000;

    // Pipeline stage numbering: input register, decay datapath, peak, output
    localparam int STAGES       = 8;
    localparam int ST_IN        = 0;
    localparam int ST_DECAY_OUT = 5;
    localparam int ST_PEAK      = 6;
    localparam int ST_OUT       = 7;

    typedef struct packed {
        logic [STAGES-1:0] valid;
        logic [STAGES-1:0] load;
    } flow_ctl_t;

endpackage

>>> rtl/apmd_flow.sv
// apmd_flow.sv - per-stage valid bits and load enables of the meter pipeline.
// Bubbles collapse: while a result is stalled, upstream stages still fill bubbles.
// Depends on apmd_pkg.
module apmd_flow
    import apmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    output logic      result_valid,
    input  logic      result_stall,
    output flow_ctl_t ctl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;
    logic              accepted;
    logic              delivered;

    // A stage may load when empty or when the stage after it loads
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? item_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = !load[0];
    assign result_valid = valid_reg[STAGES-1];
    assign ctl.valid    = valid_reg;
    assign ctl.load     = load;

    assign accepted  = item_valid && load[0];
    assign delivered = valid_reg[STAGES-1] && !result_stall;

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> $countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(accepted)) - int'($past(delivered)))
        else $error("pipeline occupancy does not match transactions in and out");

    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("input stalled although the output is draining");

    a_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> valid_reg[ST_IN])
        else $error("accepted transaction missing from the input register");

endmodule

>>> rtl/apmd_decay.sv
// apmd_decay.sv - decay amount datapath: frames from elapsed time or chunk
// length, then decay = 2*FULL_SCALE*frames/(3*rate), by reciprocal multiplies.
// Depends on apmd_pkg; load enables come from apmd_flow.
module apmd_decay
    import apmd_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = 16000
)
(
    input  logic              clk,
    input  flow_ctl_t         ctl,
    input  logic              is_chunk,
    input  logic [CLEN_W-1:0] chunk_length,
    input  logic [TIME_W-1:0] elapsed,
    output logic              sat,
    output logic [PEAK_W-1:0] decay
);

    localparam longint unsigned SR      = longint'(SAMPLE_RATE_HZ);
    localparam longint unsigned DIV_D   = 3 * SR;
    localparam longint unsigned NUM_A   = 2 * FULL_SCALE;
    // a decay above the largest held peak (PEAK_MAX), so it clears any held peak
    localparam longint unsigned SAT_DEC = PEAK_MAX + 1;
    localparam longint unsigned F_SAT   = (SAT_DEC * DIV_D + NUM_A - 1) / NUM_A;
    localparam longint unsigned E_SAT   = (MS_PER_S * F_SAT + SR - 1) / SR;
    localparam int EW  = $clog2(E_SAT);
    localparam longint unsigned PROD_MAX = (E_SAT - 1) * SR;
    localparam int PW  = $clog2(PROD_MAX + 1);
    localparam int S1  = PW + $clog2(MS_PER_S);
    localparam longint unsigned M1 = ((64'd1 << S1) + MS_PER_S - 1) / MS_PER_S;
    localparam int M1W = $clog2(M1 + 1);
    localparam int P1W = PW + M1W;
    localparam int FPW = $clog2(PROD_MAX / MS_PER_S + 1);
    localparam int FW  = $clog2(F_SAT);
    localparam int FFW_A = (FPW > CLEN_W) ? FPW : CLEN_W;
    localparam int FFW   = (FW + 1 > FFW_A) ? FW + 1 : FFW_A;
    localparam int DW  = $clog2(DIV_D);
    localparam int S2  = FW + DW;
    localparam longint unsigned M2 = (NUM_A * (64'd1 << S2) + DIV_D - 1) / DIV_D;
    localparam int M2W = $clog2(M2 + 1);
    localparam int MLW = M2W / 2;
    localparam int MHW = M2W - MLW;
    localparam int PLW = FW + MLW;
    localparam int PHW = FW + MHW;
    localparam int SUMW = FW + M2W;

    localparam logic [PW-1:0]  SR_P  = PW'(SR);
    localparam logic [M1W-1:0] M1_C  = M1W'(M1);
    localparam logic [M2W-1:0] M2_C  = M2W'(M2);
    localparam logic [MLW-1:0] M2_LO = M2_C[MLW-1:0];
    localparam logic [MHW-1:0] M2_HI = M2_C[M2W-1:MLW];

    // stage 2: captured inputs
    logic [TIME_W-1:0] el2_reg;
    logic              chunk2_reg;
    logic [CLEN_W-1:0] clen2_reg;
    // stage 3: elapsed * rate
    logic [PW-1:0]     prod3_reg;
    logic              esat3_reg;
    logic              chunk3_reg;
    logic [CLEN_W-1:0] clen3_reg;
    // stage 4: frame count
    logic [FW-1:0]     f4_reg;
    logic              sat4_reg;
    // stage 5: partial products
    logic [PLW-1:0]    pplo5_reg;
    logic [PHW-1:0]    pphi5_reg;
    logic              sat5_reg;
    // stage 6: decay amount
    logic [PEAK_W-1:0] decay6_reg;
    logic              sat6_reg;

    logic [P1W-1:0]    fp_full;
    logic [FPW-1:0]    frames_poll;
    logic [FFW-1:0]    frames;
    logic [SUMW-1:0]   sum;
    logic [PEAK_W-1:0] quot;

    always_comb
    begin
        fp_full     = P1W'(prod3_reg) * P1W'(M1_C);
        frames_poll = FPW'(fp_full >> S1);
        frames      = chunk3_reg ? FFW'(clen3_reg) : FFW'(frames_poll);
        sum         = (SUMW'(pphi5_reg) << MLW) + SUMW'(pplo5_reg);
        quot        = PEAK_W'(sum >> S2);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            el2_reg    <= elapsed;
            chunk2_reg <= is_chunk;
            clen2_reg  <= chunk_length;
        end
        if (ctl.load[2])
        begin
            prod3_reg  <= PW'(el2_reg[EW-1:0]) * SR_P;
            esat3_reg  <= el2_reg >= TIME_W'(E_SAT);
            chunk3_reg <= chunk2_reg;
            clen3_reg  <= clen2_reg;
        end
        if (ctl.load[3])
        begin
            f4_reg   <= FW'(frames);
            sat4_reg <= (!chunk3_reg && esat3_reg) || (frames >= FFW'(F_SAT));
        end
        if (ctl.load[4])
        begin
            pplo5_reg <= PLW'(f4_reg) * PLW'(M2_LO);
            pphi5_reg <= PHW'(f4_reg) * PHW'(M2_HI);
            sat5_reg  <= sat4_reg;
        end
        if (ctl.load[ST_DECAY_OUT])
        begin
            // an empty decay still takes one step off the peak
            decay6_reg <= (quot == '0) ? PEAK_W'(1) : quot;
            sat6_reg   <= sat5_reg;
        end
    end

    assign sat   = sat6_reg;
    assign decay = decay6_reg;

endmodule

>>> rtl/apmd_level.sv
// apmd_level.sv - percent level of a peak: min(100, peak*100/32767).
// Divides by 2^15-1 as a shift plus one correction step. Depends on apmd_pkg.
module apmd_level
    import apmd_pkg::*;
(
    input  logic [PEAK_W-1:0]  peak,
    output logic [LEVEL_W-1:0] level
);

    localparam int SCALE_W = $clog2(FULL_SCALE + 1);
    localparam int PROD_W  = PEAK_W + LEVEL_W;
    localparam int QW      = PROD_W - SCALE_W;

    logic [PROD_W-1:0]  scaled;
    logic [QW-1:0]      q_lo;
    logic [SCALE_W:0]   rem;
    logic [QW-1:0]      quot;

    always_comb
    begin
        scaled = PROD_W'(peak) * PROD_W'(LEVEL_MAX);
        // floor by 2^15 undershoots by at most one
        q_lo   = scaled[PROD_W-1:SCALE_W];
        rem    = (SCALE_W + 1)'(scaled[SCALE_W-1:0]) + (SCALE_W + 1)'(q_lo);
        quot   = (rem >= (SCALE_W + 1)'(FULL_SCALE)) ? q_lo + 1'b1 : q_lo;
        level  = (quot > QW'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(quot);
    end

endmodule

>>> rtl/audio_peak_meter_with_decay.sv
// audio_peak_meter_with_decay.sv - top level of the audio peak meter.
// Depends on apmd_pkg, apmd_flow, apmd_decay and apmd_level.
//
// Peak meter for a 16-bit audio stream. Each input transaction carries an op:
// chunk start decays the held peak by max(1, 2*32767*chunk_length/(3*rate))
// and stamps now_ms; sample raises the peak to the sample magnitude (-32768
// counts as 32768); time poll, once now_ms has moved on by at least
// idle_interval_ms since the last stamp, decays by the frames in the elapsed
// time and stamps; restart clears the peak and stamps. Every transaction
// returns one result with the held peak and a 0..100 percent level. The block
// takes one transaction per clock unless a stalled result has filled every
// stage. It runs through eight register stages, the input register included;
// result_valid rises when the transaction reaches the output register. The
// depth is set by the decay datapath (elapsed*rate, a reciprocal multiply for
// /1000 and a split reciprocal multiply for the decay scale, each registered).
// The time stamp and held peak are single-register loops, so back-to-back
// transactions see each other's effects. Empty stages collapse, so input is
// taken while a result waits until all are full. idle_interval_ms is written
// through cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
module audio_peak_meter_with_decay
    import apmd_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = 16000
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [IDLE_W-1:0]          cfg_wr_data,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  op_t                        op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [CLEN_W-1:0]          chunk_length,
    input  logic [TIME_W-1:0]          now_ms,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [PEAK_W-1:0]          peak,
    output logic [LEVEL_W-1:0]         level
);

    flow_ctl_t ctl;

    // Configuration register
    logic [IDLE_W-1:0] idle_reg;

    // Input register
    op_t                op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [CLEN_W-1:0]  clen_reg;
    logic [TIME_W-1:0]  now_reg;

    // Time-stamp loop
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  last_time_next;
    logic [TIME_W-1:0]  elapsed;
    logic               poll_due;
    logic               stamp;
    logic               time_move;
    logic               decay_en_next;
    logic [PEAK_W-1:0]  mag_next;

    // Side band that travels alongside the decay datapath
    op_t                op_pipe_reg  [1:ST_DECAY_OUT];
    logic [PEAK_W-1:0]  mag_pipe_reg [1:ST_DECAY_OUT];
    logic               dec_pipe_reg [1:ST_DECAY_OUT];

    logic               decay_sat;
    logic [PEAK_W-1:0]  decay_amt;

    // Peak loop and result stages
    logic [PEAK_W-1:0]  peak_reg;
    logic [PEAK_W-1:0]  peak_next;
    logic [PEAK_W-1:0]  item_peak;
    logic               peak_move;
    logic               cut;
    logic [PEAK_W-1:0]  peak7_reg;
    logic [PEAK_W-1:0]  peak_out_reg;
    logic [LEVEL_W-1:0] level_out_reg;
    logic [LEVEL_W-1:0] level_calc;

    apmd_flow u_flow
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    // Idle interval; user writes only while no transaction is in flight, unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= IDLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            idle_reg <= cfg_wr_data;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_IN])
        begin
            op_reg     <= op;
            sample_reg <= sample;
            clen_reg   <= chunk_length;
            now_reg    <= now_ms;
        end
    end

    // Time stage: elapsed time since the last stamp decides whether a poll
    // decays, and every decaying op (and restart) moves the stamp to now.
    always_comb
    begin
        elapsed   = now_reg - last_time_reg;
        poll_due  = elapsed >= TIME_W'(idle_reg);
        time_move = ctl.valid[ST_IN] && ctl.load[1];
        unique case (op_reg)
            OP_CHUNK:
            begin
                stamp         = 1'b1;
                decay_en_next = 1'b1;
            end
            OP_SAMPLE:
            begin
                stamp         = 1'b0;
                decay_en_next = 1'b0;
            end
            OP_POLL:
            begin
                stamp         = poll_due;
                decay_en_next = poll_due;
            end
            OP_RESTART:
            begin
                stamp         = 1'b1;
                decay_en_next = 1'b0;
            end
        endcase
        last_time_next = (time_move && stamp) ? now_reg : last_time_reg;
        // two's complement negate; the most negative sample wraps to 32768
        mag_next = sample_reg[SAMPLE_W-1] ? PEAK_W'(~sample_reg + 1'b1)
                                          : PEAK_W'(sample_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

    apmd_decay #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_decay
    (
        .clk          (clk),
        .ctl          (ctl),
        .is_chunk     (op_reg == OP_CHUNK),
        .chunk_length (clen_reg),
        .elapsed      (elapsed),
        .sat          (decay_sat),
        .decay        (decay_amt)
    );

    // Advance op, magnitude and decay flag in step with the decay datapath
    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            op_pipe_reg[1]  <= op_reg;
            mag_pipe_reg[1] <= mag_next;
            dec_pipe_reg[1] <= decay_en_next;
        end
        for (int k = 2; k <= ST_DECAY_OUT; k++)
        begin
            if (ctl.load[k])
            begin
                op_pipe_reg[k]  <= op_pipe_reg[k-1];
                mag_pipe_reg[k] <= mag_pipe_reg[k-1];
                dec_pipe_reg[k] <= dec_pipe_reg[k-1];
            end
        end
    end

    // Peak stage: the held peak updates as the transaction leaves the decay
    // datapath. A decay at least as large as the peak clamps it at zero.
    always_comb
    begin
        peak_move = ctl.valid[ST_DECAY_OUT] && ctl.load[ST_PEAK];
        cut       = decay_sat || (decay_amt >= peak_reg);
        unique case (op_pipe_reg[ST_DECAY_OUT])
            OP_SAMPLE:
            begin
                item_peak = (mag_pipe_reg[ST_DECAY_OUT] > peak_reg)
                          ? mag_pipe_reg[ST_DECAY_OUT] : peak_reg;
            end
            OP_RESTART:
            begin
                item_peak = '0;
            end
            OP_CHUNK, OP_POLL:
            begin
                if (!dec_pipe_reg[ST_DECAY_OUT])
                begin
                    item_peak = peak_reg;
                end
                else if (cut)
                begin
                    item_peak = '0;
                end
                else
                begin
                    item_peak = peak_reg - decay_amt;
                end
            end
        endcase
        peak_next = peak_move ? item_peak : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_PEAK])
        begin
            peak7_reg <= item_peak;
        end
        if (ctl.load[ST_OUT])
        begin
            peak_out_reg  <= peak7_reg;
            level_out_reg <= level_calc;
        end
    end

    apmd_level u_level
    (
        .peak  (peak7_reg),
        .level (level_calc)
    );

    assign peak  = peak_out_reg;
    assign level = level_out_reg;

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= PEAK_W'(PEAK_MAX))
        else $error("held peak above full-scale magnitude");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        peak_move && op_pipe_reg[ST_DECAY_OUT] == OP_RESTART |=> peak_reg == '0)
        else $error("restart did not clear the held peak");

    a_sample_raises: assert property (@(posedge clk) disable iff (!rst_n)
        peak_move && op_pipe_reg[ST_DECAY_OUT] == OP_SAMPLE
        |=> peak_reg >= $past(mag_pipe_reg[ST_DECAY_OUT]))
        else $error("held peak below the magnitude of a sample just taken");

    a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        time_move && (op_reg == OP_CHUNK || op_reg == OP_RESTART)
        |=> last_time_reg == $past(now_reg))
        else $error("chunk start or restart failed to stamp the decay time");

endmodule
